/* rtl/core/mkd_pkg.sv */
// Package for the Morse keying decoder core: register indexes, display
// geometry, symbol codes and the character pattern table with its lookup.
// No dependencies.
package mkd_pkg;

    // Display geometry and symbol run limit
    localparam int LINE_COLUMNS = 16;
    localparam int LINE_ROWS    = 2;
    localparam int MAX_SYMBOLS  = 5;

    localparam int COL_W = $clog2(LINE_COLUMNS + 2);
    localparam int ROW_W = $clog2(LINE_ROWS + 2);

    // Configuration register indexes
    localparam logic [1:0] REG_DIT_TICKS = 2'd0;
    localparam logic [1:0] REG_DAH_TICKS = 2'd1;
    localparam logic [1:0] REG_GAP_TICKS = 2'd2;

    localparam logic [15:0] DIT_TICKS_RST = 16'd50;
    localparam logic [15:0] DAH_TICKS_RST = 16'd100;
    localparam logic [15:0] GAP_TICKS_RST = 16'd200;

    // Symbol codes, two bits per symbol
    localparam logic [1:0] SYM_DIT = 2'b01;
    localparam logic [1:0] SYM_DAH = 2'b10;

    localparam int TABLE_SIZE  = 36;
    localparam int LETTERS     = 26;
    localparam int PAT_W       = 10;

    typedef logic [PAT_W-1:0] pat_t;
    typedef logic [2:0]       sym_len_t;

    // Patterns packed with the first symbol highest, last symbol in bits [1:0].
    // Order: A-Z, then 1-9, then 0.
    localparam pat_t PATTERNS [TABLE_SIZE] = '{
        10'b0000000110, 10'b0010010101, 10'b0010011001, 10'b0000100101,
        10'b0000000001, 10'b0001011001, 10'b0000101001, 10'b0001010101,
        10'b0000000101, 10'b0001101010, 10'b0000100110, 10'b0001100101,
        10'b0000001010, 10'b0000001001, 10'b0000101010, 10'b0001101001,
        10'b0010100110, 10'b0000011001, 10'b0000010101, 10'b0000000010,
        10'b0000010110, 10'b0001010110, 10'b0000011010, 10'b0010010110,
        10'b0010011010, 10'b0010100101,
        10'b0110101010, 10'b0101101010, 10'b0101011010, 10'b0101010110,
        10'b0101010101, 10'b1001010101, 10'b1010010101, 10'b1010100101,
        10'b1010101001, 10'b1010101010
    };

    localparam sym_len_t PAT_LENS [TABLE_SIZE] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd5
    };

    localparam logic [6:0] ASCII_A    = 7'd65;
    localparam logic [6:0] ASCII_ONE  = 7'd49;
    localparam logic [6:0] ASCII_ZERO = 7'd48;
    localparam logic [6:0] NO_CHAR    = 7'd0;

    // ASCII code of the held symbols, NO_CHAR when nothing matches.
    function automatic logic [6:0] mkd_lookup(input pat_t codes, input sym_len_t total);
        logic [6:0] ch;
        pat_t       mask;
        ch = NO_CHAR;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            mask = pat_t'((11'd1 << (2 * PAT_LENS[i])) - 11'd1);
            if (total == PAT_LENS[i] && (codes & mask) == PATTERNS[i]) begin
                if (i < LETTERS)
                    ch = ASCII_A + 7'(i);
                else if (i < TABLE_SIZE - 1)
                    ch = ASCII_ONE + 7'(i - LETTERS);
                else
                    ch = ASCII_ZERO;
            end
        end
        return ch;
    endfunction

endpackage

/* rtl/core/morse_keying_decoder_core.sv */
// Morse keying decoder core: key level stream in, decoded character and
// display position stream out, three threshold registers.
// Depends on mkd_pkg.
//
//  channel | dir | payload                                  | beat
//  s_      | in  | tdata[0] key_on                          | one key sample
//  m_      | out | tdata[6:0] char_code [11:7] column       | one character
//          |     |       [13:12] row                        |
//  cfg_    | in  | cfg_index, cfg_data[15:0]                | one register write
//
// One key sample per cycle while s_tready is high; the character result is
// registered as the off tick that ends the gap is accepted. The count, classify
// and table match are combinational between the state and output registers.
// A two-entry output (register plus skid) keeps s_tready high while one
// result waits; input stalls only when both entries hold results.
// aresetn is synchronous, active low; thresholds return to 50/100/200.
module morse_keying_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] key_on, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] char_code, [11:7] column, [13:12] row, [15:14] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import mkd_pkg::*;

    logic [15:0] dit_ticks_reg, dah_ticks_reg, gap_ticks_reg;
    logic [15:0] mark_count_reg, mark_count_next;
    logic [15:0] gap_count_reg, gap_count_next;
    logic [11:0] symbol_codes_reg, symbol_codes_next;
    logic [2:0]  symbol_total_reg, symbol_total_next;
    logic [COL_W-1:0] cursor_column_reg, cursor_column_next;
    logic [ROW_W-1:0] cursor_row_reg, cursor_row_next;

    logic        out_valid_reg, skid_valid_reg;
    logic [13:0] out_data_reg, skid_data_reg;

    logic        accept, key_on;
    logic [15:0] gap_inc;
    logic [11:0] codes_pre;
    logic [2:0]  total_pre;
    logic        decode_now;
    logic [6:0]  char_code;
    logic        res_valid;
    logic [13:0] res_data;
    logic        add_sym;
    logic [1:0]  sym;
    logic [COL_W-1:0] col_inc;

    assign accept    = s_tvalid && s_tready;
    assign key_on    = s_tdata[0];
    assign s_tready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_data_reg};

    always_comb begin
        gap_inc   = (gap_count_reg == 16'hFFFF) ? gap_count_reg : gap_count_reg + 16'd1;
        // drop an overlong run before it is matched or extended
        codes_pre = (symbol_total_reg > 3'(MAX_SYMBOLS)) ? '0 : symbol_codes_reg;
        total_pre = (symbol_total_reg > 3'(MAX_SYMBOLS)) ? '0 : symbol_total_reg;
        decode_now = gap_inc >= gap_ticks_reg;
        char_code  = mkd_lookup(codes_pre[PAT_W-1:0], total_pre);

        add_sym = 1'b0;
        sym     = SYM_DIT;
        if (mark_count_reg >= dit_ticks_reg && mark_count_reg < dah_ticks_reg) begin
            add_sym = 1'b1;
            sym     = SYM_DIT;
        end else if (mark_count_reg >= dah_ticks_reg) begin
            add_sym = 1'b1;
            sym     = SYM_DAH;
        end

        // cursor steps before placing the character; wrap column then row
        col_inc            = cursor_column_reg + COL_W'(1);
        cursor_column_next = col_inc;
        cursor_row_next    = cursor_row_reg;
        if (col_inc > COL_W'(LINE_COLUMNS)) begin
            cursor_column_next = COL_W'(1);
            cursor_row_next    = (cursor_row_reg >= ROW_W'(LINE_ROWS)) ? ROW_W'(1)
                                 : cursor_row_reg + ROW_W'(1);
        end

        mark_count_next   = mark_count_reg;
        gap_count_next    = gap_count_reg;
        symbol_codes_next = symbol_codes_reg;
        symbol_total_next = symbol_total_reg;
        res_valid         = 1'b0;

        if (key_on) begin
            mark_count_next = (mark_count_reg == 16'hFFFF) ? mark_count_reg
                              : mark_count_reg + 16'd1;
            gap_count_next  = '0;
        end else begin
            mark_count_next   = '0;
            gap_count_next    = gap_inc;
            symbol_codes_next = codes_pre;
            symbol_total_next = total_pre;
            if (decode_now) begin
                res_valid         = (char_code != NO_CHAR);
                symbol_codes_next = '0;
                symbol_total_next = '0;
                gap_count_next    = '0;
            end else if (add_sym) begin
                symbol_codes_next = {codes_pre[9:0], sym};
                symbol_total_next = (total_pre < 3'd7) ? total_pre + 3'd1 : total_pre;
            end
        end

        res_data = {2'(cursor_row_next), 5'(cursor_column_next), char_code};
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dit_ticks_reg <= DIT_TICKS_RST;
            dah_ticks_reg <= DAH_TICKS_RST;
            gap_ticks_reg <= GAP_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DIT_TICKS: dit_ticks_reg <= cfg_data;
                REG_DAH_TICKS: dah_ticks_reg <= cfg_data;
                REG_GAP_TICKS: gap_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_count_reg    <= '0;
            gap_count_reg     <= '0;
            symbol_codes_reg  <= '0;
            symbol_total_reg  <= '0;
            cursor_column_reg <= COL_W'(1);
            cursor_row_reg    <= ROW_W'(1);
        end else if (accept) begin
            mark_count_reg   <= mark_count_next;
            gap_count_reg    <= gap_count_next;
            symbol_codes_reg <= symbol_codes_next;
            symbol_total_reg <= symbol_total_next;
            if (res_valid) begin
                cursor_column_reg <= cursor_column_next;
                cursor_row_reg    <= cursor_row_next;
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_tready) begin
                // refill from skid first to keep order
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept && res_valid;
                    out_data_reg  <= res_data;
                end
            end else if (accept && res_valid) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res_data;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while output register is empty");

    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        symbol_total_reg <= 3'(MAX_SYMBOLS + 1))
        else $error("symbol run grew past the discard limit");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_column_reg >= COL_W'(1) && cursor_column_reg <= COL_W'(LINE_COLUMNS)
        && cursor_row_reg >= ROW_W'(1) && cursor_row_reg <= ROW_W'(LINE_ROWS))
        else $error("cursor left the display");

    a_key_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && key_on && !out_valid_reg && !skid_valid_reg) |=> !out_valid_reg)
        else $error("result appeared after an on tick");

    a_mark_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !key_on) |=> mark_count_reg == 16'd0)
        else $error("mark counter not cleared by an off tick");

endmodule

/* dv/tb_morse_keying_decoder_core.sv */
// Self-checking testbench for morse_keying_decoder_core: drives key samples and
// threshold writes, predicts each decoded character and its display position.
// Depends on mkd_pkg and the core RTL.
module tb_morse_keying_decoder_core;
    import mkd_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 10;
    localparam int RANDOM_KEYS     = 200;
    localparam int RANDOM_CHARS    = 15;
    localparam int MAX_PHASES      = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TIMEOUT_CYCLES  = 200000;
    localparam int BOOK_SIZE       = 36;

    // index 3 is not decoded by the core
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [6:0] code;
        logic [4:0] col;
        logic [1:0] row;
    } glyph_t;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PULSE} sink_mode_t;

    typedef enum int {PICK_GLYPH, PICK_BROKEN, PICK_NOISE} pick_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // [0] key_on, [7:1] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [6:0] char_code, [11:7] column, [13:12] row, [15:14] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    morse_keying_decoder_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Code book in table order: A-Z, 1-9, 0
    string morse_book [BOOK_SIZE] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        ".----", "..---", "...--", "....-", ".....", "-....", "--...", "---..",
        "----.", "-----"
    };
    string book_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";

    // Decoder state as tracked by the testbench
    logic [15:0] dit_min = DIT_TICKS_RST;
    logic [15:0] dah_min = DAH_TICKS_RST;
    logic [15:0] gap_min = GAP_TICKS_RST;
    logic [15:0] mark_ticks = 16'd0;
    logic [15:0] space_ticks = 16'd0;
    logic [11:0] held_syms = 12'd0;
    logic [2:0]  held_total = 3'd0;
    int          cur_col = 1;
    int          cur_row = 1;

    glyph_t glyphs_due [$];
    glyph_t glyph_want;

    int mismatches = 0;
    int keys_sent = 0;
    int chars_due = 0;
    int chars_checked = 0;
    int regs_written = 0;
    int burst_left = 0;
    bit steady = 1'b0;
    int hold_left = 0;

    sink_mode_t sink_mode = SINK_OPEN;
    int         sink_left = 0;

    // Character of the held symbols, NO_CHAR when the run is not in the book
    function automatic logic [6:0] held_char();
        string      seq;
        logic [1:0] sym;
        seq = "";
        for (int k = int'(held_total) - 1; k >= 0; k--) begin
            sym = held_syms[2*k +: 2];
            if (sym == SYM_DIT)
                seq = {seq, "."};
            else
                seq = {seq, "-"};
        end
        for (int i = 0; i < BOOK_SIZE; i++) begin
            if (seq == morse_book[i])
                return 7'(book_chars[i]);
        end
        return NO_CHAR;
    endfunction

    function automatic void push_symbol(input logic [1:0] sym);
        held_syms = {held_syms[9:0], sym};
        if (held_total != 3'd7)
            held_total++;
    endfunction

    // Advance the decoder state by one key sample, queue any character it emits
    function automatic void step_decoder(input bit key);
        logic [6:0] ch;
        glyph_t     g;
        if (key) begin
            if (mark_ticks != 16'hFFFF)
                mark_ticks++;
            space_ticks = 16'd0;
            return;
        end
        if (space_ticks != 16'hFFFF)
            space_ticks++;
        if (held_total > MAX_SYMBOLS) begin
            held_total = 3'd0;
            held_syms  = 12'd0;
        end
        if (space_ticks >= gap_min) begin
            ch = held_char();
            if (ch != NO_CHAR) begin
                cur_col++;
                if (cur_col > LINE_COLUMNS) begin
                    cur_col = 1;
                    cur_row++;
                    if (cur_row > LINE_ROWS)
                        cur_row = 1;
                end
                g.code = ch;
                g.col  = 5'(cur_col);
                g.row  = 2'(cur_row);
                glyphs_due.push_back(g);
                chars_due++;
            end
            held_total  = 3'd0;
            held_syms   = 12'd0;
            space_ticks = 16'd0;
        end else if (mark_ticks >= dit_min && mark_ticks < dah_min) begin
            push_symbol(SYM_DIT);
        end else if (mark_ticks >= dah_min) begin
            push_symbol(SYM_DAH);
        end
        mark_ticks = 16'd0;
    endfunction

    // Offer one key sample; bursts of random length separated by idle gaps
    task automatic send_key(input bit key);
        if (!steady && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        step_decoder(key);
        keys_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic key_run(input bit key, input int n);
        repeat (n) send_key(key);
    endtask

    // Hold the sender until every expected character is out, then let the core go quiet
    task automatic settle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (glyphs_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (glyphs_due.size() != 0) begin
            mismatches++;
            $display("%0t: %0d characters never came out", $time, glyphs_due.size());
            glyphs_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_DIT_TICKS: dit_min = val;
            REG_DAH_TICKS: dah_min = val;
            REG_GAP_TICKS: gap_min = val;
            default: ;
        endcase
        regs_written++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_thresholds(input logic [15:0] dit, input logic [15:0] dah,
                                  input logic [15:0] gap);
        settle();
        write_reg(REG_DIT_TICKS, dit);
        write_reg(REG_DAH_TICKS, dah);
        write_reg(REG_GAP_TICKS, gap);
    endtask

    function automatic int dit_len();
        int lo;
        int hi;
        lo = (dit_min == 16'd0) ? 1 : int'(dit_min);
        hi = (int'(dah_min) > lo) ? int'(dah_min) - 1 : lo;
        return $urandom_range(lo, hi);
    endfunction

    function automatic int dah_len();
        int lo;
        lo = (dah_min == 16'd0) ? 1 : int'(dah_min);
        return $urandom_range(lo, lo + 2);
    endfunction

    function automatic int space_len();
        return (gap_min >= 16'd2) ? $urandom_range(1, int'(gap_min) - 1) : 1;
    endfunction

    // Key one pattern of dots and dashes, then a closing gap
    task automatic send_glyph(input string pat);
        for (int i = 0; i < pat.len(); i++) begin
            if (pat[i] == "-")
                key_run(1'b1, dah_len());
            else
                key_run(1'b1, dit_len());
            if (i < pat.len() - 1)
                key_run(1'b0, space_len());
        end
        key_run(1'b0, ((gap_min == 16'd0) ? 1 : int'(gap_min)) + $urandom_range(0, 3));
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_key(1'($urandom_range(0, 1)));
    endtask

    function automatic string broken_pattern();
        string pat;
        pat = "";
        repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 1))
                pat = {pat, "-"};
            else
                pat = {pat, "."};
        end
        return pat;
    endfunction

    // Receiver: requested hold-offs first, otherwise a stall pattern that changes now and then
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (sink_left == 0) begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                sink_left = $urandom_range(20, 200);
            end
            sink_left--;
            case (sink_mode)
                SINK_OPEN:   m_tready <= 1'b1;
                SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= sink_left[2];
            endcase
        end
    end

    // Compare each character beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            chars_checked++;
            if (glyphs_due.size() == 0) begin
                mismatches++;
                $display("%0t: character beat with none expected, got %h", $time, m_tdata);
            end else begin
                glyph_want = glyphs_due.pop_front();
                if (m_tdata[6:0] != glyph_want.code) begin
                    mismatches++;
                    $display("%0t: char_code expected %0d got %0d", $time,
                             glyph_want.code, m_tdata[6:0]);
                end
                if (m_tdata[11:7] != glyph_want.col) begin
                    mismatches++;
                    $display("%0t: column expected %0d got %0d", $time,
                             glyph_want.col, m_tdata[11:7]);
                end
                if (m_tdata[13:12] != glyph_want.row) begin
                    mismatches++;
                    $display("%0t: row expected %0d got %0d", $time,
                             glyph_want.row, m_tdata[13:12]);
                end
            end
        end
    end

    // Thresholds out of reset: marks one below and exactly at 50 and 100
    task automatic test_reset_thresholds();
        key_run(1'b1, 49);
        key_run(1'b0, 3);
        key_run(1'b1, 99);
        key_run(1'b0, 3);
        key_run(1'b1, 50);
        key_run(1'b0, 3);
        key_run(1'b1, 100);
        key_run(1'b0, 200);
        settle();
    endtask

    // Every table entry once; enough characters to wrap the display
    task automatic test_every_character();
        set_thresholds(16'd1, 16'd3, 16'd4);
        for (int i = 0; i < BOOK_SIZE; i++)
            send_glyph(morse_book[i]);
        settle();
    endtask

    // Runs that are not in the table, over-long runs and an empty gap
    task automatic test_bad_runs();
        send_glyph(".-.-");
        send_glyph("-.-.-");
        send_glyph("......");
        send_glyph(".......");
        send_glyph("--------");
        key_run(1'b0, 12);
        send_glyph(".");
        settle();
    endtask

    // Unknown index and zero thresholds
    task automatic test_register_edges();
        write_reg(REG_SPARE, 16'hFFFF);
        send_glyph("...");
        set_thresholds(16'd0, 16'd3, 16'd6);
        send_noise(80);
        set_thresholds(16'd2, 16'd0, 16'd5);
        send_noise(60);
        set_thresholds(16'd1, 16'd2, 16'd0);
        send_noise(40);
        settle();
        write_reg(REG_SPARE, 16'd0);
        send_noise(20);
        settle();
    endtask

    // Long receiver hold-off while characters keep coming; then drain fully
    task automatic test_backpressure();
        set_thresholds(16'd1, 16'd2, 16'd2);
        hold_left = HOLD_OFF_CYCLES;
        steady = 1'b1;
        repeat (40) begin
            key_run(1'b1, 1);
            key_run(1'b0, 2);
        end
        steady = 1'b0;
        settle();
    endtask

    // Random thresholds per phase, mostly well-formed characters
    task automatic test_random_traffic();
        int    start_keys;
        int    start_chars;
        int    phase;
        pick_t pick;
        start_keys  = keys_sent;
        start_chars = chars_due;
        phase = 0;
        while ((keys_sent - start_keys < RANDOM_KEYS || chars_due - start_chars < RANDOM_CHARS)
               && phase < MAX_PHASES) begin
            set_thresholds(16'($urandom_range(1, 4)), 16'd0, 16'($urandom_range(2, 9)));
            write_reg(REG_DAH_TICKS, dit_min + 16'($urandom_range(1, 5)));
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(6, 14)) begin
                case ($urandom_range(0, 9))
                    7:       pick = PICK_BROKEN;
                    8:       pick = PICK_NOISE;
                    default: pick = PICK_GLYPH;
                endcase
                case (pick)
                    PICK_GLYPH:  send_glyph(morse_book[$urandom_range(0, BOOK_SIZE - 1)]);
                    PICK_BROKEN: send_glyph(broken_pattern());
                    default:     send_noise($urandom_range(1, 30));
                endcase
            end
            steady = 1'b0;
            phase++;
        end
        settle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_thresholds();
        test_every_character();
        test_bad_runs();
        test_register_edges();
        test_backpressure();
        test_random_traffic();
        $display("covered %0d key beats and %0d register writes across threshold settings",
                 keys_sent, regs_written);
        $display("checked %0d decoded characters, %0d mismatches", chars_checked, mismatches);
        if (mismatches == 0)
            $display("morse_keying_decoder_core regression: pass");
        else
            $display("morse_keying_decoder_core regression: fail");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("timeout with %0d characters outstanding", glyphs_due.size());
        $display("morse_keying_decoder_core regression: fail");
        $finish;
    end

endmodule
